// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== design/aia_pkg.sv =====
// Package for the accumulator/index execute unit: operation codes,
// transaction structs and flag bit positions. No dependencies.
package aia_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADC = 6'd1, OP_SUB = 6'd2, OP_SBC = 6'd3, OP_CP = 6'd4,
    OP_AND = 6'd5, OP_OR = 6'd6, OP_XOR = 6'd7, OP_BCP = 6'd8,
    OP_BSET = 6'd9, OP_BRES = 6'd10,
    OP_CLR = 6'd11, OP_CPL = 6'd12, OP_NEG = 6'd13, OP_INC = 6'd14,
    OP_DEC = 6'd15, OP_SLL = 6'd16, OP_SRA = 6'd17, OP_SRL = 6'd18,
    OP_RLC = 6'd19, OP_RRC = 6'd20, OP_SWAP = 6'd21, OP_TNZ = 6'd22,
    OP_CLRW = 6'd23, OP_TNZW = 6'd34,
    OP_ADDW = 6'd35, OP_SUBW = 6'd36, OP_CPW = 6'd37, OP_RLWA = 6'd38,
    OP_RRWA = 6'd39, OP_MUL = 6'd40, OP_EXGL = 6'd41, OP_EXGM = 6'd42,
    OP_EXGW = 6'd43, OP_ADDSP = 6'd44, OP_SUBSP = 6'd45, OP_NOP = 6'd46
  } op_t;

  // unary kinds, offset from OP_CLR / OP_CLRW
  typedef enum logic [3:0] {
    U_CLR = 4'd0, U_CPL = 4'd1, U_NEG = 4'd2, U_INC = 4'd3, U_DEC = 4'd4,
    U_SLL = 4'd5, U_SRA = 4'd6, U_SRL = 4'd7, U_RLC = 4'd8, U_RRC = 4'd9,
    U_SWAP = 4'd10, U_TNZ = 4'd11
  } ukind_t;

  localparam int FV = 7;
  localparam int FH = 4;
  localparam int FN = 2;
  localparam int FZ = 1;
  localparam int FC = 0;
  localparam logic [7:0] FLAGS_RESET = 8'h28;

  typedef struct packed {
    logic [5:0]  cmd;
    logic        to_memory;
    logic        use_y;
    logic [15:0] operand;
    logic [2:0]  bit_number;
  } in_t;

  typedef struct packed {
    logic        mem_write;
    logic [7:0]  mem_data;
    logic [7:0]  acc_out;
    logic [15:0] index_x_out;
    logic [15:0] index_y_out;
    logic [15:0] stack_out;
    logic [7:0]  flags_out;
  } out_t;

  // architectural register file
  typedef struct packed {
    logic [7:0]  accum;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] stack_ptr;
    logic [7:0]  cond_flags;
  } regs_t;

endpackage

// ===== design/aia_unary.sv =====
// Unary ALU (clear, complement, negate, inc/dec, shifts, rotates, swap, test)
// for byte or word width. Depends on aia_pkg.
module aia_unary (
  input  logic          word,
  input  logic [3:0]    kind,
  input  logic [15:0]   v,
  input  logic [7:0]    fin,
  output logic [15:0]   r,
  output logic [7:0]    fout
);
  import aia_pkg::*;

  logic [15:0] msk;
  logic [15:0] top;
  logic        vtop;
  logic        rtop;
  logic        cin;

  always_comb begin
    msk  = word ? 16'hFFFF : 16'h00FF;
    top  = word ? 16'h8000 : 16'h0080;
    vtop = word ? v[15] : v[7];
    cin  = fin[FC];
    fout = fin;
    r    = v;
    case (kind)
      U_CLR: r = '0;
      U_CPL: begin
        r = ~v & msk;
        fout[FC] = 1'b1;
      end
      U_NEG: r = (16'd0 - v) & msk;
      U_INC: r = (v + 16'd1) & msk;
      U_DEC: r = (v - 16'd1) & msk;
      U_SLL: begin
        r = (v << 1) & msk;
        fout[FC] = vtop;
      end
      U_SRA: begin
        r = (v >> 1) | (v & top);
        fout[FC] = v[0];
      end
      U_SRL: begin
        r = v >> 1;
        fout[FC] = v[0];
      end
      U_RLC: begin
        r = ((v << 1) | {15'd0, cin}) & msk;
        fout[FC] = vtop;
      end
      U_RRC: begin
        r = (v >> 1) | (cin ? top : 16'd0);
        fout[FC] = v[0];
      end
      U_SWAP: r = word ? {v[7:0], v[15:8]} : {8'd0, v[3:0], v[7:4]};
      default: r = v;
    endcase
    rtop = word ? r[15] : r[7];
    case (kind)
      U_NEG: begin
        fout[FV] = (r == top);
        fout[FC] = (r != 16'd0);
      end
      U_INC: fout[FV] = ~vtop & rtop;
      U_DEC: fout[FV] = vtop & ~rtop;
      default: ;
    endcase
    fout[FN] = rtop;
    fout[FZ] = ((r & msk) == 16'd0);
  end
endmodule

// ===== design/accumulator_index_alu.sv =====
// Top level of the accumulator/index execute unit.
// Depends on aia_pkg, aia_unary and assert_macros.svh.
//
// Executes one ALU transaction per clock while the output is not stalled:
// the input is registered, the operation is evaluated by single-pass logic
// on the register file, and the updated registers are written to both the
// state and an output register. A new transaction can be accepted every
// cycle while the output stage is free or being drained.
`include "assert_macros.svh"
module accumulator_index_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  aia_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output aia_pkg::out_t out_data
);
  import aia_pkg::*;

  regs_t       st;
  regs_t       st_next;
  in_t         item;
  logic        item_valid;
  logic        go;
  logic        mw;
  logic [7:0]  md;
  logic [15:0] reg_sel;
  logic [15:0] nreg;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] w;
  logic [8:0]  s8;
  logic [16:0] s16;
  logic        isbyte_un;
  logic        isword_un;
  logic [3:0]  ukind;
  logic [15:0] uin;
  logic [15:0] ures;
  logic [7:0]  uflags;
  logic [7:0]  f;
  logic [7:0]  bmask;

  // stage handshake: item register advances when the output slot frees
  assign go       = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  assign a     = st.accum;
  assign b     = item.operand[7:0];
  assign w     = item.operand;
  assign bmask = 8'd1 << item.bit_number;
  assign isbyte_un = (item.cmd >= OP_CLR) && (item.cmd <= OP_TNZ);
  assign isword_un = (item.cmd >= OP_CLRW) && (item.cmd <= OP_TNZW);
  assign ukind = isword_un ? 4'(item.cmd - OP_CLRW) : 4'(item.cmd - OP_CLR);
  assign reg_sel = item.use_y ? st.index_y : st.index_x;
  assign uin = isword_un ? reg_sel : {8'd0, (item.to_memory ? b : a)};

  aia_unary u_unary (
    .word (isword_un),
    .kind (ukind),
    .v    (uin),
    .fin  (st.cond_flags),
    .r    (ures),
    .fout (uflags)
  );

  // operation decode and evaluation
  always_comb begin
    st_next = st;
    f    = st.cond_flags;
    nreg = reg_sel;
    mw   = 1'b0;
    md   = 8'd0;
    s8   = '0;
    s16  = '0;
    case (item.cmd)
      OP_ADD, OP_ADC: begin
        s8 = {1'b0, a} + {1'b0, b} + {8'd0, (item.cmd == OP_ADC) & f[FC]};
        f[FC] = s8[8];
        f[FH] = a[3] & b[3] | (a[3] | b[3]) & ~s8[3];
        f[FV] = (a[7] ^ s8[7]) & (b[7] ^ s8[7]);
        f[FN] = s8[7];
        f[FZ] = (s8[7:0] == 8'd0);
        st_next.accum = s8[7:0];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        s8 = {1'b0, a} - {1'b0, b} - {8'd0, (item.cmd == OP_SBC) & f[FC]};
        f[FC] = ~a[7] & b[7] | (~a[7] | b[7]) & s8[7];
        f[FV] = (a[7] ^ b[7]) & (a[7] ^ s8[7]);
        f[FN] = s8[7];
        f[FZ] = (s8[7:0] == 8'd0);
        if (item.cmd != OP_CP) st_next.accum = s8[7:0];
      end
      OP_AND, OP_OR, OP_XOR, OP_BCP: begin
        s8[7:0] = (item.cmd == OP_AND || item.cmd == OP_BCP) ? (a & b) :
                  (item.cmd == OP_OR) ? (a | b) : (a ^ b);
        f[FN] = s8[7];
        f[FZ] = (s8[7:0] == 8'd0);
        if (item.cmd != OP_BCP) st_next.accum = s8[7:0];
      end
      OP_BSET: begin
        mw = 1'b1;
        md = b | bmask;
      end
      OP_BRES: begin
        mw = 1'b1;
        md = b & ~bmask;
      end
      OP_ADDW: begin
        s16 = {1'b0, reg_sel} + {1'b0, w};
        f[FC] = s16[16];
        f[FH] = reg_sel[7] & w[7] | (reg_sel[7] | w[7]) & ~s16[7];
        f[FV] = (reg_sel[15] ^ s16[15]) & (w[15] ^ s16[15]);
        f[FN] = s16[15];
        f[FZ] = (s16[15:0] == 16'd0);
        nreg = s16[15:0];
      end
      OP_SUBW, OP_CPW: begin
        s16 = {1'b0, reg_sel} - {1'b0, w};
        f[FC] = ~reg_sel[15] & w[15] | (~reg_sel[15] | w[15]) & s16[15];
        if (item.cmd == OP_SUBW) begin
          f[FH] = ~reg_sel[7] & w[7] | (~reg_sel[7] | w[7]) & s16[7];
          nreg = s16[15:0];
        end
        f[FV] = (reg_sel[15] ^ w[15]) & (reg_sel[15] ^ s16[15]);
        f[FN] = s16[15];
        f[FZ] = (s16[15:0] == 16'd0);
      end
      OP_RLWA, OP_RRWA: begin
        if (item.cmd == OP_RLWA) begin
          st_next.accum = reg_sel[15:8];
          nreg = {reg_sel[7:0], a};
        end else begin
          st_next.accum = reg_sel[7:0];
          nreg = {a, reg_sel[15:8]};
        end
        f[FN] = nreg[15];
        f[FZ] = (nreg == 16'd0);
      end
      OP_MUL: begin
        nreg = reg_sel[7:0] * a;
        f[FC] = 1'b0;
        f[FH] = 1'b0;
      end
      OP_EXGL: begin
        st_next.accum = reg_sel[7:0];
        nreg = {reg_sel[15:8], a};
      end
      OP_EXGM: begin
        st_next.accum = b;
        mw = 1'b1;
        md = a;
      end
      OP_EXGW: begin
        st_next.index_x = st.index_y;
        st_next.index_y = st.index_x;
      end
      OP_ADDSP: st_next.stack_ptr = st.stack_ptr + {8'd0, b};
      OP_SUBSP: st_next.stack_ptr = st.stack_ptr - {8'd0, b};
      default: begin
        if (isbyte_un) begin
          f = uflags;
          if (item.to_memory) begin
            if (ukind != U_TNZ) begin
              mw = 1'b1;
              md = ures[7:0];
            end
          end else begin
            st_next.accum = ures[7:0];
          end
        end else if (isword_un) begin
          f = uflags;
          nreg = ures;
        end
      end
    endcase
    if (item.cmd != OP_EXGW) begin
      if (item.use_y) st_next.index_y = nreg;
      else            st_next.index_x = nreg;
    end
    st_next.cond_flags = f;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{accum: 8'd0, index_x: 16'd0, index_y: 16'd0, stack_ptr: 16'd0,
              cond_flags: FLAGS_RESET};
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        st <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (go) begin
      out_data <= '{mem_write: mw, mem_data: md, acc_out: st_next.accum,
                    index_x_out: st_next.index_x, index_y_out: st_next.index_y,
                    stack_out: st_next.stack_ptr, flags_out: st_next.cond_flags};
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPLIES(a_no_mw_data, clk, rst, out_valid && !out_data.mem_write, out_data.mem_data == 8'd0)
  `ASSERT_IMPLIES(a_flag_fixed, clk, rst, 1'b1, st.cond_flags[6:5] == 2'b01 && st.cond_flags[3])

endmodule
